// File: src/esd_pkg.sv
// Package for the escape sequence decoder: result kinds, the result bundle
// passed from the front end to the back end, character codes and the hex digit decode.
// No dependencies.
package esd_pkg;

    localparam int ESD_QUEUE_DEPTH = 4;
    localparam int ESD_MAX_RESULTS = 3;

    localparam logic [31:0] CP_LIMIT = 32'h0010_FFFF;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_UPPER_N = 8'h4E;
    localparam logic [7:0] CH_UPPER_U = 8'h55;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_V = 8'h76;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    localparam logic [31:0] CP_BELL = 32'h07;
    localparam logic [31:0] CP_BS   = 32'h08;
    localparam logic [31:0] CP_FF   = 32'h0C;
    localparam logic [31:0] CP_LF   = 32'h0A;
    localparam logic [31:0] CP_CR   = 32'h0D;
    localparam logic [31:0] CP_TAB  = 32'h09;
    localparam logic [31:0] CP_VT   = 32'h0B;

    typedef enum logic [1:0] {
        KIND_CP  = 2'd0,
        KIND_END = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [31:0] code_point;
        kind_t       kind;
    } result_t;

    typedef struct packed {
        logic [1:0]  count;
        result_t [ESD_MAX_RESULTS-1:0] res;
    } bundle_t;

    // Returns the digit value in the low four bits and a valid flag in the top bit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: src/escape_sequence_decoder_top.sv
// The results of a byte are written into the queue, then loaded one at a time into the output
// register. Throughput: one byte per cycle while m_tready is high and each byte gives at most
// one result; a byte that gives two or three results holds the output register until each
// has left, and QUEUE_DEPTH queued bundles absorb the difference before s_tready falls.
// Reset (aresetn low, synchronous) clears the decode state, empties the queue and drops
// any result held in the output register.
module escape_sequence_decoder_top
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // code_point
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // run_last
);

    logic    in_fire;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    bundle_t front_bundle;
    bundle_t head;
    kind_t   out_kind;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    esd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .byte_in       (s_tdata),
        .end_of_string (s_tlast),
        .push          (push),
        .bundle        (front_bundle)
    );

    esd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_bundle),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    esd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_code_point (m_tdata),
        .out_kind       (out_kind),
        .out_last       (m_tlast)
    );

    assign m_tuser = out_kind;

endmodule

// File: src/esd_front.sv
// Front end of the escape sequence decoder: accepts one byte per beat, tracks the
// escape state and packs the results of each byte into a bundle.
// Depends on esd_pkg.
module esd_front
    import esd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  byte_in,
    input  logic        end_of_string,
    output logic        push,
    output bundle_t     bundle
);

    typedef enum logic [4:0] {
        M_NORMAL = 5'b00001,
        M_ESC    = 5'b00010,
        M_OCT    = 5'b00100,
        M_HEX    = 5'b01000,
        M_DROP   = 5'b10000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [3:0]  count_reg, count_next;
    logic [3:0]  needed_reg, needed_next;
    logic [31:0] accum_reg, accum_next;
    logic        wide_reg, wide_next;

    logic [31:0] cp_arr [ESD_MAX_RESULTS];
    kind_t       kind_arr [ESD_MAX_RESULTS];
    logic [1:0]  k;
    logic        err;
    logic [4:0]  hex;

    always_comb begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        needed_next = needed_reg;
        accum_next  = accum_reg;
        wide_next   = wide_reg;
        err         = 1'b0;
        k           = 2'd0;
        hex         = hex_digit(byte_in);
        for (int i = 0; i < ESD_MAX_RESULTS; i++) begin
            cp_arr[i]   = 32'd0;
            kind_arr[i] = KIND_CP;
        end

        unique case (mode_reg)
            M_ESC: begin
                mode_next = M_NORMAL;
                if (byte_in[7:3] == 5'b00110) begin
                    accum_next = {29'd0, byte_in[2:0]};
                    count_next = 4'd1;
                    mode_next  = M_OCT;
                end else if (byte_in == CH_LOWER_X || byte_in == CH_LOWER_U
                             || byte_in == CH_UPPER_U) begin
                    accum_next  = 32'd0;
                    count_next  = 4'd0;
                    needed_next = (byte_in == CH_LOWER_X) ? 4'd2 :
                                  ((byte_in == CH_LOWER_U) ? 4'd4 : 4'd8);
                    wide_next   = (byte_in == CH_UPPER_U);
                    mode_next   = M_HEX;
                end else if (byte_in == CH_UPPER_N) begin
                    err = 1'b1;
                end else if (byte_in == CH_NEWLINE) begin
                    k = 2'd0;
                end else begin
                    k = 2'd1;
                    unique case (byte_in)
                        CH_BSLASH:  cp_arr[0] = {24'd0, CH_BSLASH};
                        CH_QUOTE:   cp_arr[0] = {24'd0, CH_QUOTE};
                        CH_DQUOTE:  cp_arr[0] = {24'd0, CH_DQUOTE};
                        CH_LOWER_A: cp_arr[0] = CP_BELL;
                        CH_LOWER_B: cp_arr[0] = CP_BS;
                        CH_LOWER_F: cp_arr[0] = CP_FF;
                        CH_LOWER_N: cp_arr[0] = CP_LF;
                        CH_LOWER_R: cp_arr[0] = CP_CR;
                        CH_LOWER_T: cp_arr[0] = CP_TAB;
                        CH_LOWER_V: cp_arr[0] = CP_VT;
                        default: begin
                            // An unknown escape keeps both the backslash and the byte.
                            cp_arr[0] = {24'd0, CH_BSLASH};
                            cp_arr[1] = {24'd0, byte_in};
                            k         = 2'd2;
                        end
                    endcase
                end
            end
            M_OCT: begin
                if (byte_in[7:3] == 5'b00110) begin
                    accum_next = {accum_reg[28:0], byte_in[2:0]};
                    count_next = count_reg + 4'd1;
                    if (count_next >= 4'd3) begin
                        cp_arr[k] = accum_next;
                        k         = k + 2'd1;
                        mode_next = M_NORMAL;
                    end
                end else begin
                    cp_arr[k] = accum_reg;
                    k         = k + 2'd1;
                    mode_next = M_NORMAL;
                    if (byte_in != CH_BSLASH || end_of_string) begin
                        cp_arr[k] = {24'd0, byte_in};
                        k         = k + 2'd1;
                    end else begin
                        mode_next = M_ESC;
                    end
                end
            end
            M_HEX: begin
                if (!hex[4]) begin
                    err = 1'b1;
                end else begin
                    accum_next = {accum_reg[27:0], hex[3:0]};
                    count_next = count_reg + 4'd1;
                    if (count_next >= needed_reg) begin
                        mode_next = M_NORMAL;
                        if (wide_reg && accum_next > CP_LIMIT) begin
                            err = 1'b1;
                        end else begin
                            cp_arr[k] = accum_next;
                            k         = k + 2'd1;
                        end
                    end
                end
            end
            M_DROP: begin
                k = 2'd0;
            end
            default: begin
                mode_next = M_NORMAL;
                if (byte_in != CH_BSLASH || end_of_string) begin
                    cp_arr[k] = {24'd0, byte_in};
                    k         = k + 2'd1;
                end else begin
                    mode_next = M_ESC;
                end
            end
        endcase

        if (err) begin
            kind_arr[k] = KIND_ERR;
            k           = k + 2'd1;
            mode_next   = end_of_string ? M_NORMAL : M_DROP;
        end else if (end_of_string) begin
            if (mode_next == M_OCT) begin
                cp_arr[k]   = accum_next;
                k           = k + 2'd1;
                kind_arr[k] = KIND_END;
                k           = k + 2'd1;
            end else if (mode_next == M_HEX) begin
                kind_arr[k] = KIND_ERR;
                k           = k + 2'd1;
            end else if (mode_next != M_DROP) begin
                kind_arr[k] = KIND_END;
                k           = k + 2'd1;
            end
            mode_next = M_NORMAL;
        end
    end

    always_comb begin
        bundle.count = k;
        for (int i = 0; i < ESD_MAX_RESULTS; i++) begin
            bundle.res[i].code_point = cp_arr[i];
            bundle.res[i].kind       = kind_arr[i];
        end
    end

    assign push = in_fire && (k != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_NORMAL;
            count_reg  <= 4'd0;
            needed_reg <= 4'd0;
            accum_reg  <= 32'd0;
            wide_reg   <= 1'b0;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            needed_reg <= needed_next;
            accum_reg  <= accum_next;
            wide_reg   <= wide_next;
        end
    end

    a_eos_returns_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && end_of_string) |=> (mode_reg == M_NORMAL))
        else $error("decoder not back in normal mode after the last byte of a string");

    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && mode_reg == M_DROP && !end_of_string) |-> !push)
        else $error("results produced while dropping the rest of a string");

endmodule

// File: src/esd_queue.sv
// Short queue of result bundles between the front end and the back end.
// Depends on esd_pkg.
module esd_queue
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    full,
    output logic    empty
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    bundle_t         entries_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == FullCnt);
    assign empty = (fill_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("bundle pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("bundle popped from an empty queue");

endmodule

// File: src/esd_back.sv
// Back end of the escape sequence decoder: walks the results of the bundle at the
// head of the queue and presents them one per beat from an output register.
// Depends on esd_pkg.
module esd_back
    import esd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bundle_t     head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_code_point,
    output kind_t       out_kind,
    output logic        out_last
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [31:0] cp_reg;
    kind_t       kind_reg;
    logic        last_reg;
    logic        load;
    logic        at_last;
    result_t     cur;

    assign load    = !empty && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.count - 2'd1);
    assign cur     = head.res[idx_reg];
    assign pop     = load && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg   <= cur.code_point;
            kind_reg <= cur.kind;
            last_reg <= at_last;
        end
    end

    assign out_valid      = valid_reg;
    assign out_code_point = cp_reg;
    assign out_kind       = kind_reg;
    assign out_last       = last_reg;

    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> (idx_reg < head.count))
        else $error("result index beyond the bundle at the queue head");

    a_idx_clear_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> (idx_reg == 2'd0))
        else $error("result index left mid-bundle with an empty queue");

endmodule
